[rtl/plm_pkg.sv]
`default_nettype none
package plm_pkg;

  localparam int Q_W     = 32;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [CFG_W-1:0]      cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_PLANT_MODE     = 3'd0;
  localparam cfg_idx_t CFG_EFFORT_INVERT  = 3'd1;
  localparam cfg_idx_t CFG_TIME_STEP      = 3'd2;
  localparam cfg_idx_t CFG_INVERSE_MASS   = 3'd3;
  localparam cfg_idx_t CFG_FRICTION_GAIN  = 3'd4;
  localparam cfg_idx_t CFG_STICTION_LEVEL = 3'd5;
  localparam cfg_idx_t CFG_MOTOR_GAIN     = 3'd6;
  localparam cfg_idx_t CFG_BACKEMF_GAIN   = 3'd7;

  localparam logic [1:0] MODE_SERVO = 2'd2;

  // sequencer steps, one multiply each
  typedef logic [2:0] step_t;
  localparam step_t STP_DECEL = 3'd0;
  localparam step_t STP_NET   = 3'd1;
  localparam step_t STP_FORCE = 3'd2;
  localparam step_t STP_ACCEL = 3'd3;
  localparam step_t STP_VEL   = 3'd4;
  localparam step_t STP_POS   = 3'd5;
  localparam step_t STP_RATE  = 3'd6;
  localparam step_t STP_LEVEL = 3'd7;

endpackage
`default_nettype wire

[rtl/plm_if.sv]
`default_nettype none
interface plm_in_if import plm_pkg::*; ();
  logic valid;
  logic ready;
  logic op;
  q_t   effort_value;

  modport source (output valid, output op, output effort_value, input ready);
  modport sink   (input valid, input op, input effort_value, output ready);
endinterface

interface plm_out_if import plm_pkg::*; ();
  logic valid;
  logic ready;
  q_t   plant_output;

  modport source (output valid, output plant_output, input ready);
  modport sink   (input valid, input plant_output, output ready);
endinterface
`default_nettype wire

[rtl/plant_model_step.sv]
// Plant emulator for hardware-in-the-loop tests, signed fixed point with
// FRAC_BITS fraction bits.
// Input channel in_ch carries words {op, effort_value}. op=0 latches a new
// control effort (negated when effort inversion is set) and yields no result
// word. op=1 is a tick: the plant advances one Euler step and one result word
// with plant_output (level in first-order mode, position in servo mode)
// is sent on out_ch.
// Sequencing: a tick runs its multiplies one after another on a single
// 33x33 multiplier; each multiply fills the product register, then is
// rounded, saturated and accumulated: 2 multiplies in first-order mode,
// 6 in servo mode. The next word is taken in the cycle after the result
// is loaded into the output register.
// in_ch.ready is high only while the sequencer is idle.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register frees up; no state is lost.
// Configuration writes via cfg_we/cfg_index/cfg_wdata, only when idle.
// Reset (rst_n low, synchronous) restores register defaults and clears
// held effort, level, velocity and position.
`default_nettype none
module plant_model_step import plm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  plm_in_if.sink         in_ch,
  plm_out_if.source      out_ch,
  input  wire logic      cfg_we,
  input  wire cfg_idx_t  cfg_index,
  input  wire cfg_word_t cfg_wdata
);

  localparam int ONE = 1 << FRAC_BITS;
  localparam logic signed [32:0] K_TENTH    = 33'((ONE + 5) / 10);
  localparam logic signed [32:0] K_DEADBAND = 33'((ONE + 500) / 1000);
  localparam logic signed [65:0] RND        = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] Q_MAX      = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] Q_MIN      = -66'sh0_8000_0000;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic q_t sat34(logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF)       return 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    else                            return v[31:0];
  endfunction

  function automatic logic signed [33:0] ext34(q_t v);
    return {{2{v[31]}}, v};
  endfunction

  // configuration
  logic [1:0] mode_r;
  logic       rev_r;
  cfg_word_t  dt_r, invm_r, fric_r, stic_r, motor_r, bemf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd1;
      rev_r   <= 1'b0;
      dt_r    <= 31'd655;
      invm_r  <= 31'd655360;
      fric_r  <= 31'd65536;
      stic_r  <= 31'd65536;
      motor_r <= 31'd65536;
      bemf_r  <= 31'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLANT_MODE:     mode_r  <= cfg_wdata[1:0];
        CFG_EFFORT_INVERT:  rev_r   <= cfg_wdata[0];
        CFG_TIME_STEP:      dt_r    <= cfg_wdata;
        CFG_INVERSE_MASS:   invm_r  <= cfg_wdata;
        CFG_FRICTION_GAIN:  fric_r  <= cfg_wdata;
        CFG_STICTION_LEVEL: stic_r  <= cfg_wdata;
        CFG_MOTOR_GAIN:     motor_r <= cfg_wdata;
        CFG_BACKEMF_GAIN:   bemf_r  <= cfg_wdata;
      endcase
    end
  end

  logic [1:0]  state_r, state_nxt;
  step_t       step_r, step_nxt;
  q_t          held_r, held_nxt, level_r, level_nxt;
  q_t          vel_r, vel_nxt, pos_r, pos_nxt;
  logic signed [32:0] t1_r, t1_nxt;   // decel, may be +2^31
  q_t          t2_r, t2_nxt;
  logic signed [65:0] prod_r;
  logic        out_valid_r, out_valid_nxt;
  q_t          out_data_r, out_data_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_rnd;
  q_t          q_val;
  logic        in_acc, servo;
  logic signed [32:0] vel_abs, held_abs;
  logic        vel_small;
  q_t          latch_val;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign servo               = (mode_r == MODE_SERVO);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.plant_output = out_data_r;

  assign vel_abs   = vel_r[31] ? -{vel_r[31], vel_r} : {vel_r[31], vel_r};
  assign held_abs  = held_r[31] ? -{held_r[31], held_r} : {held_r[31], held_r};
  assign vel_small = (vel_abs < K_DEADBAND);

  always_comb begin
    if (!rev_r)                                latch_val = in_ch.effort_value;
    else if (in_ch.effort_value == 32'sh8000_0000) latch_val = 32'sh7FFF_FFFF;
    else                                       latch_val = -in_ch.effort_value;
  end

  // shared multiplier operand select
  always_comb begin
    unique case (step_r)
      STP_DECEL: begin mul_a = {vel_r[31], vel_r};  mul_b = {2'b00, fric_r}; end
      STP_NET:   begin mul_a = {2'b00, bemf_r};     mul_b = {vel_r[31], vel_r}; end
      STP_FORCE: begin mul_a = {2'b00, motor_r};    mul_b = {t2_r[31], t2_r}; end
      STP_ACCEL: begin mul_a = {t2_r[31], t2_r};    mul_b = {2'b00, invm_r}; end
      STP_VEL:   begin mul_a = {t2_r[31], t2_r};    mul_b = {2'b00, dt_r}; end
      STP_POS:   begin mul_a = {vel_r[31], vel_r};  mul_b = {2'b00, dt_r}; end
      STP_RATE:  begin mul_a = K_TENTH;             mul_b = {level_r[31], level_r}; end
      STP_LEVEL: begin mul_a = {t2_r[31], t2_r};    mul_b = {2'b00, dt_r}; end
    endcase
  end

  // round half up, then saturate to 32 bits
  always_comb begin
    prod_rnd = (prod_r + RND) >>> FRAC_BITS;
    if (prod_rnd > Q_MAX)      q_val = 32'sh7FFF_FFFF;
    else if (prod_rnd < Q_MIN) q_val = 32'sh8000_0000;
    else                       q_val = prod_rnd[31:0];
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    held_nxt      = held_r;
    level_nxt     = level_r;
    vel_nxt       = vel_r;
    pos_nxt       = pos_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_ch.op) begin
            held_nxt = latch_val;
          end else begin
            if (servo && vel_small) begin
              vel_nxt = '0;
              if (held_abs < {2'b00, stic_r}) held_nxt = '0;
            end
            step_nxt  = servo ? STP_DECEL : STP_RATE;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        unique case (step_r)
          STP_DECEL: t1_nxt = -{q_val[31], q_val};
          STP_NET:   t2_nxt = sat34(ext34(held_r) - ext34(q_val));
          STP_FORCE: t2_nxt = sat34(ext34(q_val) + {t1_r[32], t1_r});
          STP_ACCEL: t2_nxt = q_val;
          STP_VEL:   vel_nxt = sat34(ext34(vel_r) + ext34(q_val));
          STP_POS:   pos_nxt = sat34(ext34(pos_r) + ext34(q_val));
          STP_RATE:  t2_nxt = sat34(ext34(q_val) + ext34(held_r));
          STP_LEVEL: level_nxt = sat34(ext34(level_r) + ext34(q_val));
        endcase
        if (step_r == STP_POS || step_r == STP_LEVEL) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt  = step_r + 3'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = servo ? pos_r : level_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STP_DECEL;
      held_r      <= '0;
      level_r     <= '0;
      vel_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      held_r      <= held_nxt;
      level_r     <= level_nxt;
      vel_r       <= vel_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= mul_a * mul_b;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word without finished tick");

  a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.op && servo && vel_small) |=> (vel_r == '0))
    else $error("deadband did not zero velocity");

  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(held_r))
    else $error("held effort changed mid-tick");

  a_first_order_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && !servo) |-> (step_r == STP_RATE || step_r == STP_LEVEL))
    else $error("servo step run in first-order mode");
`endif

endmodule
`default_nettype wire
